// File: rtl/core/touch_pair_qualify_and_map_assert.svh
// Assertion macros for the touch pair qualifier.
`ifndef TOUCH_PAIR_QUALIFY_AND_MAP_ASSERT_SVH
`define TOUCH_PAIR_QUALIFY_AND_MAP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TPQM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpqm check failed");
`define TPQM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpqm check failed");
`else
`define TPQM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TPQM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/tpqm_pkg.sv
`default_nettype none
package tpqm_pkg;
    localparam int RAW_W      = 12;
    localparam int GAIN_W     = 18;
    localparam int OFS_W      = 11;
    localparam int SX_W       = 8;
    localparam int SY_W       = 9;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam int SCREEN_W_DEF    = 240;
    localparam int SCREEN_H_DEF    = 320;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIFF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 3'd6;

    localparam logic [RAW_W-1:0]         MAX_DIFF_RST = 12'd20;
    localparam logic [RAW_W-1:0]         RAW_MIN_RST  = 12'd100;
    localparam logic [RAW_W-1:0]         RAW_MAX_RST  = 12'd4000;
    localparam logic signed [GAIN_W-1:0] GAIN_RST     = 18'sd4096;
    localparam logic signed [OFS_W-1:0]  OFFSET_RST   = 11'sd0;
endpackage
`default_nettype wire

// File: rtl/core/touch_pair_qualify_and_map.sv
// The input reg captures start; the result reg then drives o_valid and the outputs.
// Throughput: one transaction per cycle; busy stays low, nothing in the path iterates.
// Each result is shown for one cycle only; the receiver cannot stall.
// Reset (synchronous, i_rst_n low) drops both valids and loads register defaults.
// Config writes are taken every cycle (o_cfg_ready high).
`default_nettype none
`include "touch_pair_qualify_and_map_assert.svh"
module touch_pair_qualify_and_map #(
    parameter int SCREEN_W    = tpqm_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H    = tpqm_pkg::SCREEN_H_DEF,
    parameter int SAMPLE_BITS = tpqm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output      logic                                busy,
    input  wire logic [SAMPLE_BITS-1:0]              i_x_first,
    input  wire logic [SAMPLE_BITS-1:0]              i_y_first,
    input  wire logic [SAMPLE_BITS-1:0]              i_x_second,
    input  wire logic [SAMPLE_BITS-1:0]              i_y_second,
    output      logic                                o_valid,
    output      logic                                o_touched,
    output      logic [tpqm_pkg::RAW_W-1:0]          o_raw_x,
    output      logic [tpqm_pkg::RAW_W-1:0]          o_raw_y,
    output      logic [tpqm_pkg::SX_W-1:0]           o_screen_x,
    output      logic [tpqm_pkg::SY_W-1:0]           o_screen_y,
    input  wire logic                                i_cfg_valid,
    output      logic                                o_cfg_ready,
    input  wire logic [tpqm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [tpqm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int RAW_W  = tpqm_pkg::RAW_W;
    localparam int GAIN_W = tpqm_pkg::GAIN_W;
    localparam int OFS_W  = tpqm_pkg::OFS_W;
    localparam int CMP_W  = (SAMPLE_BITS > RAW_W) ? SAMPLE_BITS : RAW_W;
    localparam int P_W    = SAMPLE_BITS + 1 + GAIN_W;
    localparam int Q_W    = P_W - tpqm_pkg::FRAC_W;
    localparam int S_W    = ((Q_W > 13) ? Q_W : 13) + 1;

    // configuration registers
    logic [RAW_W-1:0]         r_max_diff, r_raw_min, r_raw_max;
    logic signed [GAIN_W-1:0] r_x_gain, r_y_gain;
    logic signed [OFS_W-1:0]  r_x_offset, r_y_offset;

    // input stage
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_x1, r_y1, r_x2, r_y2;

    // result stage
    logic                   r_out_valid, r_out_touched;
    logic [RAW_W-1:0]       r_out_raw_x, r_out_raw_y;
    logic [tpqm_pkg::SX_W-1:0] r_out_sx;
    logic [tpqm_pkg::SY_W-1:0] r_out_sy;

    logic [SAMPLE_BITS-1:0] dx, dy, n_ax, n_ay;
    logic [SAMPLE_BITS:0]   sum_x, sum_y;
    logic                   n_ok;
    logic signed [P_W-1:0]  n_px, n_py;
    logic signed [Q_W-1:0]  q_x, q_y;
    logic signed [S_W-1:0]  s_x, s_y;
    logic [S_W-1:0]         c_x, c_y;
    logic [CMP_W-1:0]       ax_ext, ay_ext;
    logic                   out_zero;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_diff <= tpqm_pkg::MAX_DIFF_RST;
            r_raw_min  <= tpqm_pkg::RAW_MIN_RST;
            r_raw_max  <= tpqm_pkg::RAW_MAX_RST;
            r_x_gain   <= tpqm_pkg::GAIN_RST;
            r_x_offset <= tpqm_pkg::OFFSET_RST;
            r_y_gain   <= tpqm_pkg::GAIN_RST;
            r_y_offset <= tpqm_pkg::OFFSET_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tpqm_pkg::CFG_MAX_DIFF: r_max_diff <= i_cfg_data[RAW_W-1:0];
                tpqm_pkg::CFG_RAW_MIN:  r_raw_min  <= i_cfg_data[RAW_W-1:0];
                tpqm_pkg::CFG_RAW_MAX:  r_raw_max  <= i_cfg_data[RAW_W-1:0];
                tpqm_pkg::CFG_X_GAIN:   r_x_gain   <= $signed(i_cfg_data[GAIN_W-1:0]);
                tpqm_pkg::CFG_X_OFFSET: r_x_offset <= $signed(i_cfg_data[OFS_W-1:0]);
                tpqm_pkg::CFG_Y_GAIN:   r_y_gain   <= $signed(i_cfg_data[GAIN_W-1:0]);
                tpqm_pkg::CFG_Y_OFFSET: r_y_offset <= $signed(i_cfg_data[OFS_W-1:0]);
                default: ;
            endcase
        end
    end

    // qualify pair, average, multiply
    always_comb begin
        dx    = (r_x1 > r_x2) ? (r_x1 - r_x2) : (r_x2 - r_x1);
        dy    = (r_y1 > r_y2) ? (r_y1 - r_y2) : (r_y2 - r_y1);
        sum_x = {1'b0, r_x1} + {1'b0, r_x2};
        sum_y = {1'b0, r_y1} + {1'b0, r_y2};
        n_ax  = sum_x[SAMPLE_BITS:1];
        n_ay  = sum_y[SAMPLE_BITS:1];
        n_ok  = (CMP_W'(dx) <= CMP_W'(r_max_diff)) && (CMP_W'(dy) <= CMP_W'(r_max_diff))
             && (CMP_W'(n_ax) >= CMP_W'(r_raw_min)) && (CMP_W'(n_ax) <= CMP_W'(r_raw_max))
             && (CMP_W'(n_ay) >= CMP_W'(r_raw_min)) && (CMP_W'(n_ay) <= CMP_W'(r_raw_max));
        n_px  = $signed({1'b0, n_ax}) * r_x_gain;
        n_py  = $signed({1'b0, n_ay}) * r_y_gain;
    end

    // floor shift, offset, clamp to screen
    always_comb begin
        q_x = n_px[P_W-1:tpqm_pkg::FRAC_W];
        q_y = n_py[P_W-1:tpqm_pkg::FRAC_W];
        s_x = S_W'(q_x) + S_W'(r_x_offset);
        s_y = S_W'(q_y) + S_W'(r_y_offset);
        if (s_x[S_W-1])
            c_x = '0;
        else if (s_x > $signed(S_W'(SCREEN_W)))
            c_x = S_W'(SCREEN_W);
        else
            c_x = s_x;
        if (s_y[S_W-1])
            c_y = '0;
        else if (s_y > $signed(S_W'(SCREEN_H)))
            c_y = S_W'(SCREEN_H);
        else
            c_y = s_y;
        ax_ext = CMP_W'(n_ax);
        ay_ext = CMP_W'(n_ay);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out_touched <= 1'b0;
        end else begin
            r_in_valid    <= start && !busy;
            r_out_valid   <= r_in_valid;
            r_out_touched <= r_in_valid && n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_x1 <= i_x_first;
            r_y1 <= i_y_first;
            r_x2 <= i_x_second;
            r_y2 <= i_y_second;
        end
        if (n_ok) begin
            r_out_raw_x <= ax_ext[RAW_W-1:0];
            r_out_raw_y <= ay_ext[RAW_W-1:0];
            r_out_sx    <= c_x[tpqm_pkg::SX_W-1:0];
            r_out_sy    <= c_y[tpqm_pkg::SY_W-1:0];
        end else begin
            r_out_raw_x <= '0;
            r_out_raw_y <= '0;
            r_out_sx    <= '0;
            r_out_sy    <= '0;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_touched  = r_out_touched;
    assign o_raw_x    = r_out_raw_x;
    assign o_raw_y    = r_out_raw_y;
    assign o_screen_x = r_out_sx;
    assign o_screen_y = r_out_sy;

    assign out_zero = (o_raw_x == '0) && (o_raw_y == '0)
                   && (o_screen_x == '0) && (o_screen_y == '0);

    `TPQM_ASSERT_NEXT(a_in_to_out, i_clk, i_rst_n, r_in_valid, o_valid)
    `TPQM_ASSERT_NEXT(a_out_needs_in, i_clk, i_rst_n, !r_in_valid, !o_valid)
    `TPQM_ASSERT_SAME(a_touch_has_strobe, i_clk, i_rst_n, o_touched, o_valid)
    `TPQM_ASSERT_SAME(a_reject_zeros, i_clk, i_rst_n, o_valid && !o_touched, out_zero)
endmodule
`default_nettype wire
